// ----- rtl/core/wtps_pkg.sv -----
`timescale 1ns / 1ps

package wtps_pkg;

  // Grid side length in cells.
  localparam int SIDE = 512;

  localparam int IDX_W = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SIDE - 1);

  // Grid memory is addressed by {row, col}.
  localparam int GRID_AW = 2 * IDX_W;
  localparam int GRID_DEPTH = SIDE * (1 << IDX_W);

  localparam int VAL_W = 16;
  localparam int SUM_W = VAL_W + 2;

  // floor(x / 3) == (x * DIV3_MUL) >> DIV3_SHIFT for every x below 2**19.
  localparam int DIV3_SHIFT = 19;
  localparam int DIV3_MUL_W = 18;
  localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = DIV3_MUL_W'(174763);
  localparam int PROD_W = SUM_W + DIV3_MUL_W;

  typedef logic [VAL_W-1:0] val_t;

  // Position of one cell and its flags.
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             border;
    logic             last;
  } cell_t;

endpackage

// ----- rtl/core/wtps_if.sv -----
`timescale 1ns / 1ps

interface wtps_in_if import wtps_pkg::*; ();
  logic valid;
  logic ready;
  val_t border_value;

  modport source (output valid, output border_value, input ready);
  modport sink (input valid, input border_value, output ready);
endinterface

interface wtps_out_if import wtps_pkg::*; ();
  logic valid;
  logic ready;
  val_t cell_value;
  logic sweep_done;

  modport source (output valid, output cell_value, output sweep_done, input ready);
  modport sink (input valid, input cell_value, input sweep_done, output ready);
endinterface

// ----- rtl/core/wtps_ram.sv -----
`timescale 1ns / 1ps

module wtps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/wtps_pos.sv -----
`timescale 1ns / 1ps

module wtps_pos import wtps_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  output cell_t cur
);

  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;
  logic [IDX_W-1:0] row_next;
  logic [IDX_W-1:0] col_next;

  always_comb begin
    if (col == IDX_LAST) begin
      col_next = '0;
      row_next = (row == IDX_LAST) ? '0 : row + 1'b1;
    end else begin
      col_next = col + 1'b1;
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (advance) begin
      row <= row_next;
      col <= col_next;
    end
  end

  assign cur.row    = row;
  assign cur.col    = col;
  assign cur.border = (row == '0) || (col == '0);
  assign cur.last   = (row == IDX_LAST) && (col == IDX_LAST);

endmodule

// ----- rtl/core/wtps_calc.sv -----
`timescale 1ns / 1ps

module wtps_calc import wtps_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  cell_t               cur,
  input  val_t                border_value,
  output logic                ready,
  // memory read data for the stage-1 cell
  input  val_t                own_rd,
  input  val_t                upper_rd,
  // write-back
  output logic                wr_en,
  output logic [GRID_AW-1:0]  grid_waddr,
  output logic [IDX_W-1:0]    line_waddr,
  output val_t                wr_data,
  wtps_out_if.source          dout
);

  logic  s1_valid;
  cell_t s1_cell;
  val_t  s1_border;
  val_t  left_value;
  logic  primed;
  logic  s1_adv;

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  val_t              own;
  val_t              result;

  assign s1_adv = s1_valid && (!dout.valid || dout.ready);
  assign ready  = !s1_valid || s1_adv;

  // Own value reads as zero until the first sweep has finished.
  assign own  = primed ? own_rd : '0;
  assign sum  = SUM_W'(upper_rd) + SUM_W'(left_value) + SUM_W'(own);
  assign prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);

  always_comb begin
    if (s1_cell.border) begin
      result = s1_border;
    end else begin
      result = VAL_W'(prod >> DIV3_SHIFT);
    end
  end

  assign wr_en      = s1_adv;
  assign grid_waddr = {s1_cell.row, s1_cell.col};
  assign line_waddr = s1_cell.col;
  assign wr_data    = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      dout.valid <= 1'b0;
      left_value <= '0;
      primed     <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        dout.valid <= 1'b1;
        left_value <= result;
        if (s1_cell.last) begin
          primed <= 1'b1;
        end
      end else if (dout.ready) begin
        dout.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cell   <= cur;
      s1_border <= border_value;
    end
    if (s1_adv) begin
      dout.cell_value <= result;
      dout.sweep_done <= s1_cell.last;
    end
  end

endmodule

// ----- rtl/core/wavefront_three_point_smoothing.sv -----
`timescale 1ns / 1ps

// Three-point wavefront smoothing over a SIDE x SIDE grid of unsigned Q0.16
// values (512 x 512 by default). Each din transfer supplies the next cell of
// a raster-order sweep; cells on row 0 or column 0 take border_value, every
// other cell becomes floor((upper + left + own) / 3), where upper and left are
// this sweep's new values and own is the value from the previous sweep. Each
// din transfer yields one dout transfer carrying the new cell value, with
// sweep_done set on the last cell of the sweep. Throughput is one cell per
// clock while dout does not stall. It is set by the left-neighbor loop: the
// add, the multiply-by-reciprocal divide by 3 and the left register, with no
// other register among them. The grid lives in one memory (own value) and
// the previous row in a SIDE-deep line memory (upper value); both are read
// at the din transfer and written back when the cell leaves the update
// stage, which a dout stall can delay.
// There is no clearing pass after reset: until the first sweep completes the
// own value is taken as zero.

module wavefront_three_point_smoothing import wtps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  wtps_in_if.sink    din,
  wtps_out_if.source dout
);

  cell_t              cur;
  logic               accept;
  logic               wr_en;
  logic [GRID_AW-1:0] grid_waddr;
  logic [IDX_W-1:0]   line_waddr;
  val_t               wr_data;
  val_t               own_rd;
  val_t               upper_rd;

  assign accept = din.valid && din.ready;

  // raster position of the next cell
  wtps_pos u_pos (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .cur     (cur)
  );

  // full grid: previous-sweep value of each cell
  wtps_ram #(
    .WIDTH (VAL_W),
    .DEPTH (GRID_DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (wr_en),
    .waddr (grid_waddr),
    .wdata (wr_data),
    .re    (accept),
    .raddr ({cur.row, cur.col}),
    .rdata (own_rd)
  );

  // line memory: row above, written earlier in this sweep
  wtps_ram #(
    .WIDTH (VAL_W),
    .DEPTH (SIDE)
  ) u_line (
    .clk   (clk),
    .we    (wr_en),
    .waddr (line_waddr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (cur.col),
    .rdata (upper_rd)
  );

  // update stage, left forwarding and output register
  wtps_calc u_calc (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cur          (cur),
    .border_value (din.border_value),
    .ready        (din.ready),
    .own_rd       (own_rd),
    .upper_rd     (upper_rd),
    .wr_en        (wr_en),
    .grid_waddr   (grid_waddr),
    .line_waddr   (line_waddr),
    .wr_data      (wr_data),
    .dout         (dout)
  );

endmodule

// ----- tb/wavefront_smoothing_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels, predicts each cell's new value from its own copy of
// the grid, and compares every dout transfer against the oldest prediction.
module wavefront_smoothing_checker import wtps_pkg::*; (
  input  logic clk,
  input  logic rst,
  wtps_in_if   din,
  wtps_out_if  dout,
  output int   fail_count,
  output int   pending_cells
);

  localparam int CELL_COUNT = SIDE * SIDE;

  typedef struct {
    val_t value;
    logic done;
  } cell_result_t;

  val_t         smooth_grid [0:CELL_COUNT-1];
  val_t         left_cell;
  int unsigned  row_at;
  int unsigned  col_at;
  cell_result_t expected_cells [$];

  initial begin
    fail_count = 0;
    pending_cells = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // Gauss-Seidel update of the current cell, then advance the raster position.
  function automatic cell_result_t smooth_cell(input val_t border);
    cell_result_t res;
    logic [SUM_W-1:0] sum;
    int unsigned idx;
    idx = row_at * SIDE + col_at;
    if (row_at == 0 || col_at == 0) begin
      res.value = border;
    end else begin
      sum = SUM_W'(smooth_grid[idx - SIDE]) + SUM_W'(left_cell) + SUM_W'(smooth_grid[idx]);
      res.value = val_t'(sum / 3);
    end
    res.done = (row_at == SIDE - 1) && (col_at == SIDE - 1);
    smooth_grid[idx] = res.value;
    left_cell = res.value;
    if (col_at == SIDE - 1) begin
      col_at = 0;
      row_at = (row_at == SIDE - 1) ? 0 : row_at + 1;
    end else begin
      col_at = col_at + 1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    cell_result_t want;
    if (rst) begin
      for (int i = 0; i < CELL_COUNT; i++) smooth_grid[i] = '0;
      left_cell = '0;
      row_at = 0;
      col_at = 0;
      expected_cells.delete();
    end else begin
      // input first, so a same-edge result still finds its prediction
      if (din.valid && din.ready) expected_cells.push_back(smooth_cell(din.border_value));
      if (dout.valid && dout.ready) begin
        if (expected_cells.size() == 0) begin
          report_mismatch($sformatf("unexpected result cell_value=%h", dout.cell_value));
        end else begin
          want = expected_cells.pop_front();
          if (dout.cell_value !== want.value)
            report_mismatch($sformatf("cell_value %h, predicted %h",
                                      dout.cell_value, want.value));
          if (dout.sweep_done !== want.done)
            report_mismatch($sformatf("sweep_done %b, predicted %b",
                                      dout.sweep_done, want.done));
        end
      end
    end
    pending_cells = expected_cells.size();
  end

endmodule

// ----- tb/wavefront_three_point_smoothing_test.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the wavefront smoothing block. Prediction and
// comparison live in wavefront_smoothing_checker.
//
// Plan of the run:
//   - a few corner border values on row 0 (all ones, zero, single bits, ...)
//   - random cells with random idling on both sides for ~850 cells, which
//     covers row 0, column 0 and the first interior cells of row 1
module wavefront_three_point_smoothing_test;
  import wtps_pkg::*;

  localparam int TOTAL_CELLS = 850;
  // every transfer waits out both sides' longest gap, with a wide margin
  localparam longint unsigned CYCLE_LIMIT = 64 * longint'(TOTAL_CELLS) + 2000;
  localparam int DRAIN_CYCLES = 10;

  localparam int N_CORNER = 12;
  localparam logic [0:N_CORNER-1][VAL_W-1:0] CORNER_VALUES = {
    16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF,
    16'hFFFE, 16'hAAAA, 16'h5555, 16'h0000, 16'h00FF, 16'hFF00
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  longint unsigned cycle_count = 0;
  int fail_count;
  int pending_cells;

  wtps_in_if  din ();
  wtps_out_if dout ();

  wavefront_three_point_smoothing i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  wavefront_smoothing_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .din           (din),
    .dout          (dout),
    .fail_count    (fail_count),
    .pending_cells (pending_cells)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hang guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Idle cycles before the next transfer on either side.
  function automatic int draw_gap();
    return $urandom_range(0, 6);
  endfunction

  // Border values lean on the extremes and on lone set/clear bits, so every
  // bit of border_value goes both ways; interior cells ignore the value.
  function automatic val_t pick_border();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return '0;
      2:       return val_t'(1) << $urandom_range(0, VAL_W - 1);
      3:       return ~(val_t'(1) << $urandom_range(0, VAL_W - 1));
      default: return val_t'($urandom);
    endcase
  endfunction

  // One din transfer. Called at a falling edge and returns at one; valid is
  // lowered only when a gap is drawn, so back-to-back cells keep it high.
  task automatic send_cell(input val_t value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      din.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    din.valid = 1'b1;
    din.border_value = value;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Result side: stall a random number of cycles before each transfer.
  initial begin
    int gap;
    dout.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        dout.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      dout.ready = 1'b1;
      @(posedge clk);
      while (!dout.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    val_t value;
    din.valid = 1'b0;
    din.border_value = '0;
    // synchronous reset, released at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int n = 0; n < TOTAL_CELLS; n++) begin
      value = (n < N_CORNER) ? val_t'(CORNER_VALUES[n]) : pick_border();
      send_cell(value);
    end
    din.valid = 1'b0;

    // every prediction must be matched, then let the pipeline settle
    while (pending_cells != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
